// ===== design/assert_macros.svh =====
// Assertion macros shared by the sorted table design.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/sti_pkg.sv =====
// Package for the sorted table: field widths, operation and status codes,
// and the result struct passed from the sequencer to the top level.
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

	localparam int MODE_W  = 2;
	localparam int KEY_W   = 14;
	localparam int REC_W   = 16;
	localparam int POS_W   = 4;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 5;
	localparam int ENTRY_W = KEY_W + REC_W;

	// operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_FOUND    = 2'd2,
		ST_MISS     = 2'd3
	} status_t;

	// one finished item from the sequencer
	typedef struct packed {
		logic              valid;
		logic              inc;
		status_t           status;
		logic [POS_W-1:0]  pos;
		logic [KEY_W-1:0]  key;
		logic [REC_W-1:0]  rec;
	} sti_res_t;

endpackage

`default_nettype wire

// ===== design/sti_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sti_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/sti_seq.sv =====
// Sequencer for the sorted table: insert shift, bisection and positional read
// over the entry RAM. Depends on sti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sti_seq import sti_pkg::*; #(
	parameter int CAPACITY = 16,
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic [REC_W-1:0]   record_id,
	input  wire logic [POS_W-1:0]   position,
	input  wire logic [CW-1:0]      count,
	output logic                    busy,
	output sti_res_t                res,
	output logic                    mem_we,
	output logic [IW-1:0]           mem_waddr,
	output logic [ENTRY_W-1:0]      mem_wdata,
	output logic [IW-1:0]           mem_raddr,
	input  wire logic [ENTRY_W-1:0] mem_rdata
);

	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_PUT,
		S_SRCH_ISSUE,
		S_SRCH_CMP,
		S_RD_WAIT,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [KEY_W-1:0] key_q;
	logic [REC_W-1:0] rec_q;
	logic [IW-1:0]    pos_q;
	logic [CW-1:0]    j_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hx_q;
	logic [IW-1:0]    mid_q;
	status_t          fin_q;

	logic [CW:0]      mid_sum;
	logic [IW-1:0]    mid;
	logic [CW-1:0]    cnt_m1;
	logic [CW-1:0]    j_m1;
	logic [CW-1:0]    j_m2;
	logic [KEY_W-1:0] rkey;
	logic [REC_W-1:0] rrec;
	logic             is_full;
	logic             pos_ok;
	logic             shift;

	// bisection middle: (lo + hi) / 2 with hi = hx - 1
	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - {{CW{1'b0}}, 1'b1};
	assign mid     = mid_sum[IW:1];
	assign cnt_m1  = count - {{(CW-1){1'b0}}, 1'b1};
	assign j_m1    = j_q - {{(CW-1){1'b0}}, 1'b1};
	assign j_m2    = j_q - {{(CW-2+1){1'b0}}, 1'b1} - {{(CW-1){1'b0}}, 1'b1};
	assign rkey    = mem_rdata[ENTRY_W-1 -: KEY_W];
	assign rrec    = mem_rdata[REC_W-1:0];
	assign is_full = (count == CW'(CAPACITY));
	assign pos_ok  = (CMP_W'(position) < CMP_W'(count));
	assign shift   = (rkey < key_q);
	assign busy    = (state_q != S_IDLE);

	// memory controls and result
	always_comb begin
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = j_q[IW-1:0];
		mem_wdata = {key_q, rec_q};
		res       = '0;
		res.status = ST_MISS;
		case (state_q)
			S_IDLE: begin
				if (start && mode == MODE_INSERT) begin
					mem_raddr = cnt_m1[IW-1:0];
				end else if (start && mode == MODE_READ) begin
					mem_raddr = IW'(position);
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (shift) begin
					mem_wdata = mem_rdata;
					mem_raddr = j_m2[IW-1:0];
				end else begin
					res.valid  = 1'b1;
					res.inc    = 1'b1;
					res.status = ST_INSERTED;
					res.pos    = POS_W'(j_q);
					res.key    = key_q;
					res.rec    = rec_q;
				end
			end
			S_INS_PUT: begin
				mem_we     = 1'b1;
				res.valid  = 1'b1;
				res.inc    = 1'b1;
				res.status = ST_INSERTED;
				res.pos    = POS_W'(j_q);
				res.key    = key_q;
				res.rec    = rec_q;
			end
			S_SRCH_ISSUE: begin
				if (lo_q < hx_q) begin
					mem_raddr = mid;
				end else begin
					res.valid = 1'b1;
				end
			end
			S_SRCH_CMP: begin
				if (rkey == key_q) begin
					res.valid  = 1'b1;
					res.status = ST_FOUND;
					res.pos    = POS_W'(mid_q);
					res.key    = rkey;
					res.rec    = rrec;
				end
			end
			S_RD_WAIT: begin
				res.valid  = 1'b1;
				res.status = ST_FOUND;
				res.pos    = POS_W'(pos_q);
				res.key    = rkey;
				res.rec    = rrec;
			end
			S_FIN: begin
				res.valid  = 1'b1;
				res.status = fin_q;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= key;
						rec_q <= record_id;
						pos_q <= IW'(position);
						lo_q  <= '0;
						hx_q  <= count;
						j_q   <= count;
						fin_q <= ST_MISS;
						case (mode)
							MODE_INSERT: begin
								if (is_full) begin
									fin_q   <= ST_FULL;
									state_q <= S_FIN;
								end else if (count == '0) begin
									state_q <= S_INS_PUT;
								end else begin
									state_q <= S_INS_CMP;
								end
							end
							MODE_SEARCH: state_q <= S_SRCH_ISSUE;
							MODE_READ:   state_q <= pos_ok ? S_RD_WAIT : S_FIN;
							default:     state_q <= S_FIN;
						endcase
					end
				end
				S_INS_CMP: begin
					if (shift) begin
						j_q <= j_m1;
						if (j_m1 == '0) begin
							state_q <= S_INS_PUT;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SRCH_ISSUE: begin
					mid_q <= mid;
					state_q <= (lo_q < hx_q) ? S_SRCH_CMP : S_IDLE;
				end
				S_SRCH_CMP: begin
					if (rkey == key_q) begin
						state_q <= S_IDLE;
					end else begin
						if (rkey < key_q) begin
							hx_q <= CW'(mid_q);
						end else begin
							lo_q <= CW'(mid_q) + {{(CW-1){1'b0}}, 1'b1};
						end
						state_q <= S_SRCH_ISSUE;
					end
				end
				S_INS_PUT, S_RD_WAIT, S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/sorted_table_insert_and_binary_search.sv =====
// Sorted (key, record id) table kept in descending key order.
// Command channel: an item is taken when start is high and busy is low.
// Mode 0 inserts after all entries with key >= the new key, mode 1 bisects
// for an exact key, mode 2 reads the entry at a position, mode 3 does nothing.
// Each item gives one result, shown for exactly one cycle with done high;
// the receiver cannot stall and must take it then.
// An insert moves entries one at a time from the end, then writes the new entry;
// a search makes at most clog2(CAPACITY + 1) probes, ending on a hit or a miss;
// a read waits for its RAM word; full and nop give their status without the RAM.
// The rate is set by the single read and write port of the entry RAM:
// an insert moves one entry per cycle, a probe takes a read then a compare.
// busy is low again in the done cycle, so the next item can be taken then.
// Reset clears the entry count and sequencer; RAM contents need no clearing,
// as only entries below the count are ever read. entry_count is the count
// after the item. Depends on sti_pkg, sti_ram, sti_seq and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_table_insert_and_binary_search import sti_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [KEY_W-1:0]  key,
	input  wire logic [REC_W-1:0]  record_id,
	input  wire logic [POS_W-1:0]  position,
	output logic                   done,
	output logic [STAT_W-1:0]      status,
	output logic [POS_W-1:0]       found_position,
	output logic [KEY_W-1:0]       found_key,
	output logic [REC_W-1:0]       found_record,
	output logic [CNT_W-1:0]       entry_count
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	sti_res_t           res;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [IW-1:0]      mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	logic               done_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_nx;
	logic [STAT_W-1:0]  status_q;
	logic [POS_W-1:0]   pos_q;
	logic [KEY_W-1:0]   key_q;
	logic [REC_W-1:0]   rec_q;
	logic [CNT_W-1:0]   cnt_out_q;

	sti_seq #(.CAPACITY(CAPACITY)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.key       (key),
		.record_id (record_id),
		.position  (position),
		.count     (count_q),
		.busy      (busy),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sti_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign count_nx = count_q + CW'(res.inc);

	// strobe and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= res.valid;
			if (res.valid) begin
				count_q <= count_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q  <= res.status;
			pos_q     <= res.pos;
			key_q     <= res.key;
			rec_q     <= res.rec;
			cnt_out_q <= CNT_W'(count_nx);
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_position = pos_q;
	assign found_key      = key_q;
	assign found_record   = rec_q;
	assign entry_count    = cnt_out_q;

	// checks
	`ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)
	`ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`ASSERT_IMPL(a_ins_count, clk, arst_n, done_q && status_q == ST_INSERTED, count_q == CW'($past(count_q) + 1'b1))

endmodule

`default_nettype wire
